// ----- rtl/assert_macros.svh -----
// Assertion macros included by the back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PMCSL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");
`define PMCSL_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");
`else
`define PMCSL_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define PMCSL_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/pmcsl_pkg.sv -----
// Types and constants of the print move command speed limiter.
package pmcsl_pkg;

   localparam int CSR_IDX_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_EXTRUSION_SCALE    = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SPEED          = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRAVEL_SPEED       = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_EXTRUDER_SPEED = 8'd3;

   localparam logic [1:0] KIND_LINE = 2'd0;
   localparam logic [1:0] KIND_CW   = 2'd1;
   localparam logic [1:0] KIND_CCW  = 2'd2;

   localparam logic [31:0] SAT_U32 = 32'hFFFF_FFFF;

   typedef struct packed {
      logic signed [31:0] extrusion_scale;
      logic [30:0]        min_speed;
      logic [30:0]        travel_speed;
      logic [30:0]        max_extruder_speed;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
      logic signed [31:0] layer_z;
      logic [30:0]        seg_speed;
      logic signed [31:0] extr_factor;
      logic signed [31:0] abs_extrusion;
      logic [1:0]         arc_kind;
      logic [18:0]        arc_angle;
      logic signed [31:0] center_off_x;
      logic signed [31:0] center_off_y;
      logic               travel;
      logic               is_arc;
   } item_type;

   typedef struct packed {
      logic [1:0]         cmd_kind;
      logic signed [31:0] target_x;
      logic signed [31:0] target_y;
      logic signed [31:0] target_z;
      logic signed [31:0] e_amount;
      logic [30:0]        feed_speed;
      logic signed [31:0] arc_i;
      logic signed [31:0] arc_j;
      logic               last;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_TRAVEL, ST_SQ_A, ST_SQ_B, ST_SQ_SUM, ST_SQRT, ST_LEN, ST_ARC,
      ST_EF, ST_PA, ST_PB, ST_PSUM, ST_NUM, ST_DIV0, ST_DIV, ST_OUT
   } state_type;

endpackage

// ----- rtl/pmcsl_front.sv -----
// Front end: takes segment words, flags travel and arc, queues them.
module pmcsl_front
   import pmcsl_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic signed [31:0] start_x,
   input  logic signed [31:0] start_y,
   input  logic signed [31:0] end_x,
   input  logic signed [31:0] end_y,
   input  logic signed [31:0] layer_z,
   input  logic [30:0]        seg_speed,
   input  logic signed [31:0] extr_factor,
   input  logic signed [31:0] abs_extrusion,
   input  logic [1:0]         arc_kind,
   input  logic [18:0]        arc_angle,
   input  logic signed [31:0] center_off_x,
   input  logic signed [31:0] center_off_y,
   input  logic               head_pop,
   output logic               head_empty,
   output item_type           head
);

   logic [31:0] last_x_ff, last_y_ff, last_z_ff;
   item_type    mem_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  count_ff;
   logic        accept;
   item_type    item;

   assign full       = (count_ff == 2'd2);
   assign head_empty = (count_ff == 2'd0);
   assign accept     = push && !full;
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      item.start_x       = start_x;
      item.start_y       = start_y;
      item.end_x         = end_x;
      item.end_y         = end_y;
      item.layer_z       = layer_z;
      item.seg_speed     = seg_speed;
      item.extr_factor   = extr_factor;
      item.abs_extrusion = abs_extrusion;
      item.arc_kind      = arc_kind;
      item.arc_angle     = arc_angle;
      item.center_off_x  = center_off_x;
      item.center_off_y  = center_off_y;
      item.travel        = (last_x_ff != start_x) || (last_y_ff != start_y) ||
                           (last_z_ff != layer_z);
      item.is_arc        = (arc_kind == KIND_CW) || (arc_kind == KIND_CCW);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_x_ff <= '0;
         last_y_ff <= '0;
         last_z_ff <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (accept) begin
            last_x_ff <= end_x;
            last_y_ff <= end_y;
            last_z_ff <= layer_z;
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (head_pop && !head_empty) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(accept) - 2'(head_pop && !head_empty);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mem_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

// ----- rtl/pmcsl_rspq.sv -----
// Two-entry command queue on the result side.
module pmcsl_rspq
   import pmcsl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type head
);

   cmd_type    mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(do_push) - 2'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/pmcsl_back.sv -----
// Back end: length, extrusion and speed limit sequencer on one multiplier.
`include "assert_macros.svh"
module pmcsl_back
   import pmcsl_pkg::*;
#(
   parameter int FRAC_BITS = 16
)
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     head_empty,
   input  item_type head,
   output logic     head_pop,
   input  logic     cmd_full,
   output logic     cmd_push,
   output cmd_type  cmd
);

   state_type          state_ff, state_in;
   item_type           item_ff;
   logic [31:0]        ua_ff, ub_ff, root_ff, len_ff;
   logic [63:0]        mul_p_ff, acc_ff, rad_ff;
   logic [34:0]        srem_ff;
   logic [4:0]         cnt_ff;
   logic [30:0]        ahi_ff, cs_ff, spd_ff, q_ff;
   logic [62:0]        m_ff, drem_ff;
   logic [93:0]        dd_ff;
   logic signed [63:0] e_ff;

   logic [31:0]        mul_a, mul_b, mag_ef, mag_sc;
   logic [63:0]        mul_full;
   logic [32:0]        dx, dy;
   logic [31:0]        ua_ld, ub_ld;
   logic [64:0]        sq_sum;
   logic [36:0]        srem_sh, trial;
   logic               sq_ge;
   logic [63:0]        arc_sh;
   logic [31:0]        arc_len;
   logic [94:0]        prod_full, prod_sh;
   logic [62:0]        m_val;
   logic               sgn_neg;
   logic [93:0]        div_lim;
   logic               div_big, div_ge;
   logic [30:0]        q_nx;
   logic signed [63:0] e_sum;
   logic signed [31:0] e_sat;
   logic               srem_bound;

   always_comb begin
      mag_ef = item_ff.extr_factor[31] ? 32'(-item_ff.extr_factor) : item_ff.extr_factor;
      mag_sc = cfg.extrusion_scale[31] ? 32'(-cfg.extrusion_scale)
                                       : cfg.extrusion_scale;
      dx = {head.end_x[31], head.end_x} - {head.start_x[31], head.start_x};
      dy = {head.end_y[31], head.end_y} - {head.start_y[31], head.start_y};
      if (head.is_arc) begin
         ua_ld = head.center_off_x[31] ? 32'(-head.center_off_x) : head.center_off_x;
         ub_ld = head.center_off_y[31] ? 32'(-head.center_off_y) : head.center_off_y;
      end else begin
         ua_ld = dx[32] ? 32'(-dx) : dx[31:0];
         ub_ld = dy[32] ? 32'(-dy) : dy[31:0];
      end
   end

   // shared multiplier, product registered every cycle
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_SQ_A: begin mul_a = ua_ff; mul_b = ua_ff; end
         ST_SQ_B: begin mul_a = ub_ff; mul_b = ub_ff; end
         ST_LEN:  begin mul_a = root_ff; mul_b = {13'd0, item_ff.arc_angle}; end
         ST_EF:   begin mul_a = len_ff; mul_b = mag_ef; end
         ST_PA:   begin mul_a = mul_p_ff[31:0]; mul_b = mag_sc; end
         ST_PB:   begin mul_a = {1'b0, ahi_ff}; mul_b = mag_sc; end
         ST_NUM:  begin mul_a = {1'b0, cfg.max_extruder_speed}; mul_b = len_ff; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
      mul_full = mul_a * mul_b;
   end

   always_comb begin
      sq_sum     = {1'b0, acc_ff} + {1'b0, mul_p_ff};
      srem_sh    = {srem_ff, rad_ff[63:62]};
      trial      = {3'd0, root_ff, 2'b01};
      sq_ge      = (srem_sh >= trial);
      arc_sh     = mul_p_ff >> FRAC_BITS;
      arc_len    = (arc_sh[63:32] != 32'd0) ? SAT_U32 : arc_sh[31:0];
      prod_full  = {31'd0, acc_ff} + {mul_p_ff[62:0], 32'd0};
      prod_sh    = prod_full >> (2 * FRAC_BITS);
      m_val      = (prod_sh > (95'd1 << 62)) ? (63'd1 << 62) : prod_sh[62:0];
      sgn_neg    = item_ff.extr_factor[31] ^ cfg.extrusion_scale[31];
      div_lim    = {m_ff, 31'd0};
      div_big    = ({31'd0, mul_p_ff[62:0]} >= div_lim);
      div_ge     = ({31'd0, drem_ff} >= dd_ff);
      q_nx       = {q_ff[29:0], div_ge};
      e_sum      = e_ff + 64'(item_ff.abs_extrusion);
      if (e_sum > 64'sd2147483647) begin
         e_sat = 32'sh7FFF_FFFF;
      end else if (e_sum < -64'sd2147483648) begin
         e_sat = 32'sh8000_0000;
      end else begin
         e_sat = e_sum[31:0];
      end
      srem_bound = ({2'd0, srem_ff} <= {root_ff, 5'd0});
   end

   always_comb begin
      state_in = state_ff;
      head_pop = 1'b0;
      cmd_push = 1'b0;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!head_empty) begin
               head_pop = 1'b1;
               state_in = head.travel ? ST_TRAVEL : ST_SQ_A;
            end
         end
         ST_TRAVEL: begin
            cmd.cmd_kind   = KIND_LINE;
            cmd.target_x   = item_ff.start_x;
            cmd.target_y   = item_ff.start_y;
            cmd.target_z   = item_ff.layer_z;
            cmd.feed_speed = cfg.travel_speed;
            cmd_push       = !cmd_full;
            if (!cmd_full) begin
               state_in = ST_SQ_A;
            end
         end
         ST_SQ_A:   state_in = ST_SQ_B;
         ST_SQ_B:   state_in = ST_SQ_SUM;
         ST_SQ_SUM: state_in = sq_sum[64] ? ST_LEN : ST_SQRT;
         ST_SQRT:   state_in = (cnt_ff == 5'd0) ? ST_LEN : ST_SQRT;
         ST_LEN:    state_in = item_ff.is_arc ? ST_ARC : ST_EF;
         ST_ARC:    state_in = ST_EF;
         ST_EF:     state_in = ST_PA;
         ST_PA:     state_in = ST_PB;
         ST_PB:     state_in = ST_PSUM;
         ST_PSUM:   state_in = ST_NUM;
         ST_NUM:    state_in = (m_ff == 63'd0 || sgn_neg) ? ST_OUT : ST_DIV0;
         ST_DIV0:   state_in = div_big ? ST_OUT : ST_DIV;
         ST_DIV:    state_in = (cnt_ff == 5'd0) ? ST_OUT : ST_DIV;
         ST_OUT: begin
            cmd.cmd_kind   = item_ff.is_arc ? item_ff.arc_kind : KIND_LINE;
            cmd.target_x   = item_ff.end_x;
            cmd.target_y   = item_ff.end_y;
            cmd.target_z   = item_ff.layer_z;
            cmd.e_amount   = e_sat;
            cmd.feed_speed = spd_ff;
            cmd.arc_i      = item_ff.is_arc ? item_ff.center_off_x : 32'sd0;
            cmd.arc_j      = item_ff.is_arc ? item_ff.center_off_y : 32'sd0;
            cmd.last       = 1'b1;
            cmd_push       = !cmd_full;
            if (!cmd_full) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      mul_p_ff <= mul_full;
      unique case (state_ff)
         ST_IDLE: begin
            item_ff <= head;
            ua_ff   <= ua_ld;
            ub_ff   <= ub_ld;
            cs_ff   <= (head.seg_speed > cfg.min_speed) ? head.seg_speed : cfg.min_speed;
         end
         ST_SQ_B: acc_ff <= mul_p_ff;
         ST_SQ_SUM: begin
            rad_ff  <= sq_sum[63:0];
            srem_ff <= '0;
            root_ff <= sq_sum[64] ? SAT_U32 : 32'd0;
            cnt_ff  <= 5'd31;
         end
         ST_SQRT: begin
            // one result bit per step
            rad_ff <= {rad_ff[61:0], 2'b00};
            if (sq_ge) begin
               srem_ff <= 35'(srem_sh - trial);
               root_ff <= {root_ff[30:0], 1'b1};
            end else begin
               srem_ff <= srem_sh[34:0];
               root_ff <= {root_ff[30:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 5'd1;
         end
         ST_LEN: len_ff <= root_ff;
         ST_ARC: len_ff <= arc_len;
         ST_PA:  ahi_ff <= mul_p_ff[62:32];
         ST_PB:  acc_ff <= mul_p_ff;
         ST_PSUM: m_ff <= m_val;
         ST_NUM: begin
            if (m_ff == 63'd0) begin
               e_ff   <= '0;
               spd_ff <= cfg.travel_speed;
            end else if (sgn_neg) begin
               e_ff   <= -$signed({1'b0, m_ff});
               spd_ff <= cs_ff;
            end else begin
               e_ff   <= $signed({1'b0, m_ff});
               spd_ff <= cs_ff;
            end
         end
         ST_DIV0: begin
            drem_ff <= mul_p_ff[62:0];
            dd_ff   <= {1'b0, m_ff, 30'd0};
            q_ff    <= '0;
            cnt_ff  <= 5'd30;
         end
         ST_DIV: begin
            if (div_ge) begin
               drem_ff <= 63'(drem_ff - dd_ff[62:0]);
            end
            dd_ff  <= {1'b0, dd_ff[93:1]};
            q_ff   <= q_nx;
            cnt_ff <= cnt_ff - 5'd1;
            if (cnt_ff == 5'd0 && q_nx < cs_ff) begin
               spd_ff <= q_nx;
            end
         end
         default: begin
         end
      endcase
   end

   `PMCSL_ASSERT_IMP(a_push_room, clock, reset, cmd_push, !cmd_full)
   `PMCSL_ASSERT_NXT(a_sqrt_done, clock, reset, state_ff == ST_SQRT && cnt_ff == 5'd0, state_ff == ST_LEN)
   `PMCSL_ASSERT_IMP(a_div_fits, clock, reset, state_ff == ST_DIV, {31'd0, drem_ff} < {dd_ff[92:0], 1'b0} || dd_ff[93])
   `PMCSL_ASSERT_IMP(a_sqrt_rem, clock, reset, state_ff == ST_SQRT, srem_bound)

endmodule

// ----- rtl/print_move_command_speed_limiter.sv -----
// Top level: register file, front end, back end and command queue.
//
//   channel  | handshake            | words
//   req_     | push / full          | one print segment
//   rsp_     | empty / pop          | one motion command, one or two per segment
//   csr_     | valid / ready        | register index and data
//
// A segment runs through the back end sequencer after its pop off the front queue:
// a 32-step square root, unless the sum of squares overflows, and for a positive
// extrusion a 31-step quotient share the sequencer and its one 32x32 multiplier.
// A travel move and an arc each add a state; stalls on a full command queue hold it.
// Reset is synchronous; registers return to their defaults, last position to zero.
// Two segments queue at the front and two commands at the back.
module print_move_command_speed_limiter
   import pmcsl_pkg::*;
#(
   parameter int FRAC_BITS = 16
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic signed [31:0]   req_start_x,
   input  logic signed [31:0]   req_start_y,
   input  logic signed [31:0]   req_end_x,
   input  logic signed [31:0]   req_end_y,
   input  logic signed [31:0]   req_layer_z,
   input  logic [30:0]          req_seg_speed,
   input  logic signed [31:0]   req_extr_factor,
   input  logic signed [31:0]   req_abs_extrusion,
   input  logic [1:0]           req_arc_kind,
   input  logic [18:0]          req_arc_angle,
   input  logic signed [31:0]   req_center_off_x,
   input  logic signed [31:0]   req_center_off_y,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [1:0]           rsp_cmd_kind,
   output logic signed [31:0]   rsp_target_x,
   output logic signed [31:0]   rsp_target_y,
   output logic signed [31:0]   rsp_target_z,
   output logic signed [31:0]   rsp_e_amount,
   output logic [30:0]          rsp_feed_speed,
   output logic signed [31:0]   rsp_arc_i,
   output logic signed [31:0]   rsp_arc_j,
   output logic                 rsp_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);

   cfg_type  cfg_ff;
   item_type head;
   logic     head_empty, head_pop;
   logic     cmd_full, cmd_push;
   cmd_type  cmd, rsp_head;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.extrusion_scale    <= 32'sd65536;
         cfg_ff.min_speed          <= 31'd0;
         cfg_ff.travel_speed       <= 31'd196608000;
         cfg_ff.max_extruder_speed <= 31'd655360;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_EXTRUSION_SCALE:    cfg_ff.extrusion_scale    <= csr_data;
            CSR_MIN_SPEED:          cfg_ff.min_speed          <= csr_data[30:0];
            CSR_TRAVEL_SPEED:       cfg_ff.travel_speed       <= csr_data[30:0];
            CSR_MAX_EXTRUDER_SPEED: cfg_ff.max_extruder_speed <= csr_data[30:0];
            default: begin
               // drop writes to unknown registers
            end
         endcase
      end
   end

   pmcsl_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (req_push),
      .full          (req_full),
      .start_x       (req_start_x),
      .start_y       (req_start_y),
      .end_x         (req_end_x),
      .end_y         (req_end_y),
      .layer_z       (req_layer_z),
      .seg_speed     (req_seg_speed),
      .extr_factor   (req_extr_factor),
      .abs_extrusion (req_abs_extrusion),
      .arc_kind      (req_arc_kind),
      .arc_angle     (req_arc_angle),
      .center_off_x  (req_center_off_x),
      .center_off_y  (req_center_off_y),
      .head_pop      (head_pop),
      .head_empty    (head_empty),
      .head          (head)
   );

   pmcsl_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_empty (head_empty),
      .head       (head),
      .head_pop   (head_pop),
      .cmd_full   (cmd_full),
      .cmd_push   (cmd_push),
      .cmd        (cmd)
   );

   pmcsl_rspq u_rspq (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd),
      .full      (cmd_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .head      (rsp_head)
   );

   assign rsp_cmd_kind   = rsp_head.cmd_kind;
   assign rsp_target_x   = rsp_head.target_x;
   assign rsp_target_y   = rsp_head.target_y;
   assign rsp_target_z   = rsp_head.target_z;
   assign rsp_e_amount   = rsp_head.e_amount;
   assign rsp_feed_speed = rsp_head.feed_speed;
   assign rsp_arc_i      = rsp_head.arc_i;
   assign rsp_arc_j      = rsp_head.arc_j;
   assign rsp_last       = rsp_head.last;

endmodule
